// ===== rtl/lcp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcp_pkg
// Shared types, codes and keyword tables of the line command parser.
// ----------------------------------------------------------------------------
package lcp_pkg;

  localparam int MAX_LINE   = 50;
  localparam int LEN_W      = 6;
  localparam int KW_COUNT   = 6;
  localparam int KW_OFF     = 0;
  localparam int KW_SCALE_F = 1;
  localparam int KW_SCALE_C = 2;
  localparam int KW_STOP    = 3;
  localparam int KW_START   = 4;
  localparam int KW_PERIOD  = 5;
  localparam int PREFIX_LEN = 7;
  localparam int KW_CHARS   = 8;

  localparam logic [31:0] MAG_CAP = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

  localparam logic [7:0] BYTE_NUL   = 8'd0;
  localparam logic [7:0] BYTE_LF    = 8'd10;
  localparam logic [7:0] BYTE_TAB   = 8'd9;
  localparam logic [7:0] BYTE_CR    = 8'd13;
  localparam logic [7:0] BYTE_SPACE = 8'd32;
  localparam logic [7:0] BYTE_PLUS  = 8'd43;
  localparam logic [7:0] BYTE_MINUS = 8'd45;
  localparam logic [7:0] BYTE_ZERO  = 8'd48;
  localparam logic [7:0] BYTE_NINE  = 8'd57;

  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_CHARS] = '{
    '{"O", "F", "F", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"S", "C", "A", "L", "E", "=", "F", 8'd0},
    '{"S", "C", "A", "L", "E", "=", "C", 8'd0},
    '{"S", "T", "O", "P", 8'd0, 8'd0, 8'd0, 8'd0},
    '{"S", "T", "A", "R", "T", 8'd0, 8'd0, 8'd0},
    '{"P", "E", "R", "I", "O", "D", "=", 8'd0}
  };

  localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
    LEN_W'(3), LEN_W'(7), LEN_W'(7), LEN_W'(4), LEN_W'(5), LEN_W'(7)
  };

  typedef enum logic [3:0] {
    EV_NONE     = 4'd0,
    EV_OFF      = 4'd1,
    EV_SCALE_F  = 4'd2,
    EV_SCALE_C  = 4'd3,
    EV_STOP     = 4'd4,
    EV_START    = 4'd5,
    EV_PERIOD   = 4'd6,
    EV_UNKNOWN  = 4'd7,
    EV_TOO_LONG = 4'd8
  } event_t;

  typedef enum logic [1:0] {
    NP_BEFORE = 2'd0,
    NP_SIGN   = 2'd1,
    NP_DIGITS = 2'd2,
    NP_DONE   = 2'd3
  } num_phase_t;

  typedef struct packed {
    event_t      ev;
    logic        scale_fahrenheit;
    logic        stopped;
    logic [31:0] report_period;
    logic        halted;
  } result_t;

endpackage

// ===== rtl/lcp_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcp_in_stage
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module lcp_in_stage import lcp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  assign in_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      held_byte <= rx_byte;
    end
  end

endmodule

// ===== rtl/lcp_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcp_engine
// Line state, keyword matching and number reading; one byte per cycle while take is high.
// ----------------------------------------------------------------------------
module lcp_engine import lcp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] rx_byte,
  output result_t    res
);

  logic [LEN_W-1:0]    line_length, line_length_next;
  logic [KW_COUNT-1:0] keyword_alive, keyword_alive_next;
  num_phase_t          number_phase, number_phase_next;
  logic                number_negative, number_negative_next;
  logic [31:0]         number_value, number_value_next;
  logic                scale_flag, scale_flag_next;
  logic                stop_flag, stop_flag_next;
  logic [31:0]         period_value, period_value_next;
  logic                halt_flag, halt_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length     <= '0;
      keyword_alive   <= '1;
      number_phase    <= NP_BEFORE;
      number_negative <= 1'b0;
      number_value    <= '0;
      scale_flag      <= 1'b1;
      stop_flag       <= 1'b0;
      period_value    <= 32'd1;
      halt_flag       <= 1'b0;
    end else if (take) begin
      line_length     <= line_length_next;
      keyword_alive   <= keyword_alive_next;
      number_phase    <= number_phase_next;
      number_negative <= number_negative_next;
      number_value    <= number_value_next;
      scale_flag      <= scale_flag_next;
      stop_flag       <= stop_flag_next;
      period_value    <= period_value_next;
      halt_flag       <= halt_flag_next;
    end
  end

  always_comb begin
    logic        digit;
    logic        space;
    logic        accumulate;
    logic [35:0] product;
    logic [31:0] number_out;
    logic [LEN_W:0] count;
    event_t      ev;

    line_length_next     = line_length;
    keyword_alive_next   = keyword_alive;
    number_phase_next    = number_phase;
    number_negative_next = number_negative;
    number_value_next    = number_value;
    scale_flag_next      = scale_flag;
    stop_flag_next       = stop_flag;
    period_value_next    = period_value;
    halt_flag_next       = halt_flag;
    ev                   = EV_NONE;

    digit      = (rx_byte >= BYTE_ZERO) && (rx_byte <= BYTE_NINE);
    space      = (rx_byte == BYTE_SPACE) || ((rx_byte >= BYTE_TAB) && (rx_byte <= BYTE_CR));
    accumulate = 1'b0;
    product    = ({4'b0, number_value} << 3) + ({4'b0, number_value} << 1)
               + 36'(rx_byte - BYTE_ZERO);
    number_out = number_negative ? (32'd0 - number_value)
               : ((number_value > POS_MAX) ? POS_MAX : number_value);
    count      = {1'b0, line_length} + (LEN_W + 1)'(1);

    if (!halt_flag && rx_byte != BYTE_NUL) begin
      if (rx_byte == BYTE_LF) begin
        ev = EV_UNKNOWN;
        priority if (keyword_alive[KW_OFF] && line_length == KW_LEN[KW_OFF]) begin
          ev             = EV_OFF;
          halt_flag_next = 1'b1;
        end else if (keyword_alive[KW_SCALE_F] && line_length == KW_LEN[KW_SCALE_F]) begin
          ev              = EV_SCALE_F;
          scale_flag_next = 1'b1;
        end else if (keyword_alive[KW_SCALE_C] && line_length == KW_LEN[KW_SCALE_C]) begin
          ev              = EV_SCALE_C;
          scale_flag_next = 1'b0;
        end else if (keyword_alive[KW_STOP] && line_length == KW_LEN[KW_STOP]) begin
          ev             = EV_STOP;
          stop_flag_next = 1'b1;
        end else if (keyword_alive[KW_START] && line_length == KW_LEN[KW_START]) begin
          ev             = EV_START;
          stop_flag_next = 1'b0;
        end else if (keyword_alive[KW_PERIOD] && line_length > LEN_W'(PREFIX_LEN)) begin
          ev                = EV_PERIOD;
          period_value_next = number_out;
        end else begin
          ev = EV_UNKNOWN;
        end
        line_length_next     = '0;
        keyword_alive_next   = '1;
        number_phase_next    = NP_BEFORE;
        number_negative_next = 1'b0;
        number_value_next    = '0;
      end else begin
        for (int k = 0; k < KW_COUNT; k++) begin
          if (keyword_alive[k]) begin
            if (k == KW_PERIOD && line_length >= LEN_W'(PREFIX_LEN)) begin
              keyword_alive_next[k] = 1'b1;
            end else if (line_length < KW_LEN[k]
                         && KW_TEXT[k][line_length[2:0]] == rx_byte) begin
              keyword_alive_next[k] = 1'b1;
            end else begin
              keyword_alive_next[k] = 1'b0;
            end
          end
        end

        if (line_length >= LEN_W'(PREFIX_LEN)) begin
          unique case (number_phase)
            NP_BEFORE: begin
              if (space) begin
                number_phase_next = NP_BEFORE;
              end else if (rx_byte == BYTE_PLUS || rx_byte == BYTE_MINUS) begin
                number_negative_next = (rx_byte == BYTE_MINUS);
                number_phase_next    = NP_SIGN;
              end else if (!digit) begin
                number_phase_next = NP_DONE;
              end else begin
                number_phase_next = NP_DIGITS;
                accumulate        = 1'b1;
              end
            end
            NP_SIGN, NP_DIGITS: begin
              if (!digit) begin
                number_phase_next = NP_DONE;
              end else begin
                number_phase_next = NP_DIGITS;
                accumulate        = 1'b1;
              end
            end
            NP_DONE: begin
              number_phase_next = NP_DONE;
            end
          endcase
          if (accumulate) begin
            number_value_next = (product > {4'b0, MAG_CAP}) ? MAG_CAP : product[31:0];
          end
        end

        line_length_next = count[LEN_W-1:0];
        if (count >= (LEN_W + 1)'(MAX_LINE)) begin
          ev                   = EV_TOO_LONG;
          line_length_next     = '0;
          keyword_alive_next   = '1;
          number_phase_next    = NP_BEFORE;
          number_negative_next = 1'b0;
          number_value_next    = '0;
        end
      end
    end

    res.ev               = ev;
    res.scale_fahrenheit = scale_flag_next;
    res.stopped          = stop_flag_next;
    res.report_period    = period_value_next;
    res.halted           = halt_flag_next;
  end

endmodule

// ===== rtl/lcp_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcp_out_stage
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module lcp_out_stage import lcp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    held_valid,
  input  result_t res_in,
  output logic    advance,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t res
);

  assign advance = held_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_in;
    end
  end

endmodule

// ===== rtl/line_command_parser_core.sv =====
`timescale 1ns / 1ps
// path: an accepted byte is held in the input register, and its result item in the result register
// throughput: one byte per cycle while out_stall does not hold the result register
// reset: synchronous; clears the pending line, scale Fahrenheit, not stopped,
// period one, not halted; no item is held after reset
// ----------------------------------------------------------------------------
// line_command_parser_core
// Splits received bytes into lines and decodes the command on each line.
// ----------------------------------------------------------------------------
module line_command_parser_core import lcp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         event_res,
  output logic               scale_fahrenheit,
  output logic               stopped,
  output logic signed [31:0] report_period,
  output logic               halted
);

  logic       advance;
  logic       held_valid;
  logic [7:0] held_byte;
  result_t    res_next;
  result_t    res;

  lcp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  lcp_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .take    (advance),
    .rx_byte (held_byte),
    .res     (res_next)
  );

  lcp_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .res_in     (res_next),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .res        (res)
  );

  assign event_res        = res.ev;
  assign scale_fahrenheit = res.scale_fahrenheit;
  assign stopped          = res.stopped;
  assign report_period    = res.report_period;
  assign halted           = res.halted;

endmodule
